[hdl/cwh_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cwh_pkg
// Shared types and constants for the colour wheel hue to rgb core.
// ----------------------------------------------------------------------------
package cwh_pkg;

	localparam int FUNC_W   = 2;
	localparam int FIELD_W  = 12;
	localparam int COLOUR_W = 8;
	localparam int IDX_W    = 5;
	localparam int ATAN_LEN = 24;
	localparam int PRE_SHIFT = 24;

	localparam logic [FUNC_W-1:0] FUNC_PRESS   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_MOVE    = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;

	localparam logic [COLOUR_W-1:0] COLOUR_FULL = 8'd255;

	typedef logic [31:0] turn32_t;

	// arctangent of 2^-i in 2^32 units per turn
	function automatic turn32_t atan_turn32(input logic [IDX_W-1:0] idx);
		turn32_t r;
		case (idx)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

	typedef struct packed {
		logic             latch;
		logic             load;
		logic             step;
		logic [IDX_W-1:0] step_idx;
		logic             sect;
		logic             ramp;
		logic             load_out;
	} cwh_cmd_t;

	typedef struct packed {
		logic bypass;
	} cwh_status_t;

endpackage

`default_nettype wire

[hdl/cwh_ptr_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cwh_ptr_if
// Pointer event channel: function code and pointer coordinates.
// ----------------------------------------------------------------------------
interface cwh_ptr_if;
	import cwh_pkg::*;

	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [FIELD_W-1:0]  pointer_x;
	logic [FIELD_W-1:0]  pointer_y;

	modport source (output valid, output func, output pointer_x, output pointer_y,
		input ready);
	modport sink (input valid, input func, input pointer_x, input pointer_y,
		output ready);
endinterface

`default_nettype wire

[hdl/cwh_rgb_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cwh_rgb_if
// Picked colour channel.
// ----------------------------------------------------------------------------
interface cwh_rgb_if;
	import cwh_pkg::*;

	logic                valid;
	logic                ready;
	logic [COLOUR_W-1:0] red;
	logic [COLOUR_W-1:0] green;
	logic [COLOUR_W-1:0] blue;
	logic                at_center;

	modport source (output valid, output red, output green, output blue,
		output at_center, input ready);
	modport sink (input valid, input red, input green, input blue,
		input at_center, output ready);
endinterface

`default_nettype wire

[hdl/cwh_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cwh_ctrl
// Sequencer: capture arming, cordic step count, output register occupancy.
// ----------------------------------------------------------------------------
module cwh_ctrl #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	input  wire [cwh_pkg::FUNC_W-1:0] in_func,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire                      out_ready,
	output cwh_pkg::cwh_cmd_t        cmd,
	input  wire cwh_pkg::cwh_status_t status
);
	import cwh_pkg::*;

	localparam int STEPS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STEPS - 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_STEP   = 3'd1;
	localparam logic [2:0] ST_SECT   = 3'd2;
	localparam logic [2:0] ST_RAMP   = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	logic [2:0]       state_q, state_d;
	logic [IDX_W-1:0] cnt_q, cnt_d;
	logic             armed_q, armed_d;
	logic             full_q, full_d;
	logic             accept;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = full_q;
	assign accept    = in_valid && in_ready;

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		armed_d      = armed_q;
		full_d       = full_q;
		cmd          = '0;
		cmd.step_idx = cnt_q;
		if (full_q && out_ready) begin
			full_d = 1'b0;
		end
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_func)
						FUNC_PRESS: begin
							cmd.latch = 1'b1;
							armed_d   = 1'b1;
						end
						FUNC_RELEASE: begin
							armed_d = 1'b0;
						end
						FUNC_MOVE: begin
							if (armed_q) begin
								cmd.load = 1'b1;
								cnt_d    = '0;
								state_d  = ST_STEP;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_STEP: begin
				if (status.bypass) begin
					state_d = ST_SECT;
				end else begin
					cmd.step = 1'b1;
					if (cnt_q == LAST_IDX) begin
						state_d = ST_SECT;
					end else begin
						cnt_d = cnt_q + 1'b1;
					end
				end
			end
			ST_SECT: begin
				cmd.sect = 1'b1;
				state_d  = ST_RAMP;
			end
			ST_RAMP: begin
				cmd.ramp = 1'b1;
				state_d  = ST_FINISH;
			end
			ST_FINISH: begin
				if (!full_q || out_ready) begin
					cmd.load_out = 1'b1;
					full_d       = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			armed_q <= 1'b0;
			full_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			armed_q <= armed_d;
			full_q  <= full_d;
		end
	end

endmodule

`default_nettype wire

[hdl/cwh_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cwh_datapath
// Centre store, offset set-up, shared cordic vectoring step, sector mapping.
// ----------------------------------------------------------------------------
module cwh_datapath #(
	parameter int COORD_BITS = 12,
	parameter int ANGLE_BITS = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire [cwh_pkg::FIELD_W-1:0]   pointer_x,
	input  wire [cwh_pkg::FIELD_W-1:0]   pointer_y,
	input  wire cwh_pkg::cwh_cmd_t       cmd,
	output cwh_pkg::cwh_status_t         status,
	output logic [cwh_pkg::COLOUR_W-1:0] red,
	output logic [cwh_pkg::COLOUR_W-1:0] green,
	output logic [cwh_pkg::COLOUR_W-1:0] blue,
	output logic                         at_center
);
	import cwh_pkg::*;

	localparam int W      = COORD_BITS + PRE_SHIFT + 3;
	localparam int TRIM   = 32 - ANGLE_BITS;
	localparam int SC_W   = ANGLE_BITS + 3;
	localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
	localparam logic [ANGLE_BITS-1:0] HALF    = ANGLE_BITS'(2) << (ANGLE_BITS - 2);
	localparam logic [ANGLE_BITS-1:0] THREE_Q = ANGLE_BITS'(3) << (ANGLE_BITS - 2);

	logic [COORD_BITS-1:0] cx_q, cy_q, px, py;
	logic signed [COORD_BITS:0] u, v, a, b;
	logic signed [W-1:0] x_q, y_q, x_init, y_init, xs, ys;
	logic [ANGLE_BITS-1:0] z_q, z_init;
	logic bypass_q, bypass_d, centre_q, centre_d;
	logic [32:0] atan_round;
	logic [ANGLE_BITS-1:0] atan_step;
	logic y_pos;
	logic [SC_W-1:0] scaled;
	logic [2:0] sector_s1;
	logic [ANGLE_BITS-1:0] frac_s1;
	logic [ANGLE_BITS+7:0] ramp_prod;
	logic [COLOUR_W-1:0] ramp, r_d, g_d, b_d;
	logic [COLOUR_W-1:0] red_s2, green_s2, blue_s2;

	// centre latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
		end else if (cmd.latch) begin
			cx_q <= px;
			cy_q <= py;
		end
	end

	assign px = COORD_BITS'(pointer_x);
	assign py = COORD_BITS'(pointer_y);

	// offset set-up, up is positive v
	always_comb begin
		u = $signed({1'b0, px}) - $signed({1'b0, cx_q});
		v = $signed({1'b0, cy_q}) - $signed({1'b0, py});
		a = v[COORD_BITS] ? -v : v;
		b = v[COORD_BITS] ? -u : u;
		x_init = $signed({{2{a[COORD_BITS]}}, a, {PRE_SHIFT{1'b0}}});
		y_init = $signed({{2{b[COORD_BITS]}}, b, {PRE_SHIFT{1'b0}}});
		centre_d = (u == '0) && (v == '0);
		bypass_d = (u == '0) || (v == '0);
		if (u == '0) begin
			z_init = (!v[COORD_BITS] && v != '0) ? '0 : HALF;
		end else if (v == '0) begin
			z_init = u[COORD_BITS] ? THREE_Q : QUARTER;
		end else begin
			z_init = v[COORD_BITS] ? HALF : '0;
		end
	end

	assign status.bypass = bypass_q;

	// one vectoring step
	always_comb begin
		xs         = x_q >>> cmd.step_idx;
		ys         = y_q >>> cmd.step_idx;
		y_pos      = !y_q[W-1] && (y_q != '0);
		atan_round = {1'b0, atan_turn32(cmd.step_idx)} + (33'(1) << (TRIM - 1));
		atan_step  = ANGLE_BITS'(atan_round >> TRIM);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bypass_q <= 1'b0;
			centre_q <= 1'b0;
		end else if (cmd.load) begin
			bypass_q <= bypass_d;
			centre_q <= centre_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= x_init;
			y_q <= y_init;
			z_q <= z_init;
		end else if (cmd.step) begin
			if (y_pos) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_step;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_step;
			end
		end
	end

	// sector split and ramp
	assign scaled = {z_q, 2'b00} + {1'b0, z_q, 1'b0};

	always_ff @(posedge clk) begin
		if (cmd.sect) begin
			sector_s1 <= scaled[SC_W-1:ANGLE_BITS];
			frac_s1   <= scaled[ANGLE_BITS-1:0];
		end
	end

	always_comb begin
		ramp_prod = {frac_s1, 8'b0} - {8'b0, frac_s1};
		ramp      = ramp_prod[ANGLE_BITS+7:ANGLE_BITS];
		r_d = '0;
		g_d = '0;
		b_d = '0;
		case (sector_s1)
			3'd0: begin
				r_d = COLOUR_FULL;
				g_d = ramp;
			end
			3'd1: begin
				g_d = COLOUR_FULL;
				r_d = COLOUR_FULL - ramp;
			end
			3'd2: begin
				g_d = COLOUR_FULL;
				b_d = ramp;
			end
			3'd3: begin
				b_d = COLOUR_FULL;
				g_d = COLOUR_FULL - ramp;
			end
			3'd4: begin
				b_d = COLOUR_FULL;
				r_d = ramp;
			end
			default: begin
				r_d = COLOUR_FULL;
				b_d = COLOUR_FULL - ramp;
			end
		endcase
		if (centre_q) begin
			r_d = '0;
			g_d = '0;
			b_d = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ramp) begin
			red_s2   <= r_d;
			green_s2 <= g_d;
			blue_s2  <= b_d;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			red       <= red_s2;
			green     <= green_s2;
			blue      <= blue_s2;
			at_center <= centre_q;
		end
	end

endmodule

`default_nettype wire

[hdl/color_wheel_hue_to_rgb_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// a pointer move passes through the load, the cordic vectoring steps, the sector, ramp and
// finish states; no steps are taken when the pointer lies on an axis or at the centre
// the core takes no new event until a move has finished, as the cordic step unit is shared;
// the finish state waits while a held result is not taken; press and release return to idle
// reset: centre cleared, capture disarmed, output register empty
// ----------------------------------------------------------------------------
// color_wheel_hue_to_rgb_core
// Colour wheel picker: pointer offset from a latched centre to an rgb hue.
// ----------------------------------------------------------------------------
module color_wheel_hue_to_rgb_core #(
	parameter int COORD_BITS   = 12,
	parameter int ANGLE_BITS   = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  wire       clk,
	input  wire       arst_n,
	cwh_ptr_if.sink   pointer,
	cwh_rgb_if.source color
);
	import cwh_pkg::*;

	cwh_cmd_t    cmd;
	cwh_status_t status;

	cwh_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pointer.valid),
		.in_func   (pointer.func),
		.in_ready  (pointer.ready),
		.out_valid (color.valid),
		.out_ready (color.ready),
		.cmd       (cmd),
		.status    (status)
	);

	cwh_datapath #(
		.COORD_BITS(COORD_BITS),
		.ANGLE_BITS(ANGLE_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.pointer_x (pointer.pointer_x),
		.pointer_y (pointer.pointer_y),
		.cmd       (cmd),
		.status    (status),
		.red       (color.red),
		.green     (color.green),
		.blue      (color.blue),
		.at_center (color.at_center)
	);

endmodule

`default_nettype wire

[hdl/cwh_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cwh_checker
// Port-level checks on the colour wheel core, bound to the top level.
// ----------------------------------------------------------------------------
module cwh_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          in_ready,
	input wire                          out_valid,
	input wire                          out_ready,
	input wire [cwh_pkg::COLOUR_W-1:0]  red,
	input wire [cwh_pkg::COLOUR_W-1:0]  green,
	input wire [cwh_pkg::COLOUR_W-1:0]  blue,
	input wire                          at_center
);
	import cwh_pkg::*;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({red, green, blue, at_center}))
		else $error("stalled result changed");

	// centre gives black
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && at_center |-> red == '0 && green == '0 && blue == '0)
		else $error("centre result not black");

	// one channel saturated and one empty off centre
	a_hue: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !at_center |->
		(red == COLOUR_FULL || green == COLOUR_FULL || blue == COLOUR_FULL) &&
		(red == '0 || green == '0 || blue == '0))
		else $error("result is not a pure hue");

	// a new result only appears after the sequencer has left idle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while idle");

endmodule

bind color_wheel_hue_to_rgb_core cwh_checker u_cwh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (pointer.ready),
	.out_valid (color.valid),
	.out_ready (color.ready),
	.red       (color.red),
	.green     (color.green),
	.blue      (color.blue),
	.at_center (color.at_center)
);

`default_nettype wire
